@@ design/fr_pkg.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared types and fixed-point constants for the reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [60:0] ONE_Q60    = 61'h1000_0000_0000_0000;
   localparam logic [62:0] HALF_Q46   = 63'h0000_2000_0000_0000;
   localparam logic [15:0] REFL_ONE   = 16'h8000;
   localparam int          SQRT_STEPS = 31;
   localparam int          DIV1_STEPS = 30;
   localparam int          DIV2_STEPS = 31;

   typedef struct packed {
      logic [30:0] cos_i;
      logic [15:0] eta_i;
      logic [15:0] eta_t;
      logic        tir;
   } side_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [33:0] den;
      logic [30:0] quo;
      logic        den_zero;
   } div_lane_type;

endpackage

@@ design/fresnel_reflectance.sv @@
// ----------------------------------------------------------------------------
// Fresnel reflectance
// Unpolarized Fresnel reflectance of a surface hit, fully pipelined.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  incident, normal, two indices
//   rsp      out        rsp_valid/rsp_stall  reflectance, total_internal
//
// One item enters per cycle while rsp_stall is not holding a result; each item
// passes through the chains of one-bit-per-stage square root and divider
// stages. Reset clears the valid bits of every stage. A result held by
// rsp_stall freezes the whole pipeline, and req_stall follows it.
// ----------------------------------------------------------------------------
module fresnel_reflectance #(
   parameter int COMPONENT_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_incident_x,
   input  logic signed [15:0] req_incident_y,
   input  logic signed [15:0] req_incident_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic        [15:0] req_index_incident,
   input  logic        [15:0] req_index_transmit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [15:0] rsp_reflectance,
   output logic               rsp_total_internal
);
   import fr_pkg::*;

   localparam int DOT_SHIFT = 2 * COMPONENT_FRAC_BITS;

   function automatic logic [121:0] sqrt_step(input logic [60:0] v, input logic [60:0] r,
                                              input logic [60:0] bitv);
      logic [61:0] sum;
      sum = {1'b0, r} + {1'b0, bitv};
      if ({1'b0, v} >= sum) begin
         return {v - sum[60:0], (r >> 1) + bitv};
      end
      return {v, r >> 1};
   endfunction

   logic adv;
   logic rsp_valid_ff;
   logic [15:0] rsp_reflectance_ff, rsp_reflectance_in;
   logic rsp_total_internal_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage A: component products.
   logic a_valid_ff;
   logic signed [31:0] a_prod_ff [3];
   logic [15:0] a_ei_ff, a_et_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
      if (adv) begin
         a_prod_ff[0] <= req_incident_x * req_normal_x;
         a_prod_ff[1] <= req_incident_y * req_normal_y;
         a_prod_ff[2] <= req_incident_z * req_normal_z;
         a_ei_ff      <= req_index_incident;
         a_et_ff      <= req_index_transmit;
      end
   end

   // Stage B: dot product, cosine clamp and index swap.
   logic b_valid_ff;
   side_type b_side_ff, b_side_in;
   logic signed [33:0] dot_in;
   logic [33:0] mag_in;
   logic [44:0] cwide_in;
   logic swap_in;

   assign dot_in = 34'(a_prod_ff[0]) + 34'(a_prod_ff[1]) + 34'(a_prod_ff[2]);
   assign mag_in = dot_in[33] ? 34'($unsigned(-dot_in)) : 34'($unsigned(dot_in));
   assign swap_in = !dot_in[33] && (dot_in != 34'sd0);

   if (DOT_SHIFT > 30) begin : g_round
      assign cwide_in = (45'(mag_in) + (45'(1) << (DOT_SHIFT - 31))) >> (DOT_SHIFT - 30);
   end else begin : g_scale
      assign cwide_in = 45'(mag_in) << (30 - DOT_SHIFT);
   end

   always_comb begin
      b_side_in.cos_i = (cwide_in > 45'(ONE_Q30)) ? ONE_Q30 : cwide_in[30:0];
      b_side_in.eta_i = swap_in ? a_et_ff : a_ei_ff;
      b_side_in.eta_t = swap_in ? a_ei_ff : a_et_ff;
      b_side_in.tir   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         b_side_ff <= b_side_in;
      end
   end

   // Incident sine: square root of one minus cosine squared.
   logic [60:0] s1_v_ff [SQRT_STEPS+1];
   logic [60:0] s1_r_ff [SQRT_STEPS+1];
   logic [60:0] s1_v_in [SQRT_STEPS+1];
   logic [60:0] s1_r_in [SQRT_STEPS+1];
   side_type    s1_side_ff [SQRT_STEPS+1];
   logic        s1_valid_ff [SQRT_STEPS+1];
   logic [61:0] csq_in;

   assign csq_in = b_side_ff.cos_i * b_side_ff.cos_i;
   assign s1_v_in[0] = ONE_Q60 - csq_in[60:0];
   assign s1_r_in[0] = '0;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt1
      logic [121:0] step;
      assign step = sqrt_step(s1_v_ff[j], s1_r_ff[j], 61'(1) << (2 * (SQRT_STEPS - 1 - j)));
      assign s1_v_in[j+1] = step[121:61];
      assign s1_r_in[j+1] = step[60:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            s1_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff[0] <= b_valid_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            s1_valid_ff[k] <= s1_valid_ff[k-1];
         end
      end
      if (adv) begin
         s1_side_ff[0] <= b_side_ff;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            s1_v_ff[k] <= s1_v_in[k];
            s1_r_ff[k] <= s1_r_in[k];
         end
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            s1_side_ff[k] <= s1_side_ff[k-1];
         end
      end
   end

   // Total internal reflection test and transmitted sine division.
   logic [46:0] d1_rem_ff [DIV1_STEPS+1];
   logic [29:0] d1_q_ff   [DIV1_STEPS+1];
   logic [46:0] d1_rem_in [DIV1_STEPS+1];
   logic [29:0] d1_q_in   [DIV1_STEPS+1];
   side_type    d1_side_ff [DIV1_STEPS+1];
   side_type    d1_side_in;
   logic        d1_valid_ff [DIV1_STEPS+1];
   logic [30:0] sini;

   assign sini = s1_r_ff[SQRT_STEPS][30:0];
   assign d1_rem_in[0] = s1_side_ff[SQRT_STEPS].eta_i * sini;
   assign d1_q_in[0] = '0;

   always_comb begin
      d1_side_in = s1_side_ff[SQRT_STEPS];
      d1_side_in.tir = (d1_side_in.eta_t == 16'd0) ||
                       (d1_rem_in[0] >= {1'b0, d1_side_in.eta_t, 30'd0});
   end

   for (genvar j = 0; j < DIV1_STEPS; j++) begin : g_div1
      logic [46:0] dvs;
      logic        take;
      assign dvs  = 47'(d1_side_ff[j].eta_t) << (DIV1_STEPS - 1 - j);
      assign take = d1_rem_ff[j] >= dvs;
      assign d1_rem_in[j+1] = take ? d1_rem_ff[j] - dvs : d1_rem_ff[j];
      assign d1_q_in[j+1]   = {d1_q_ff[j][28:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV1_STEPS; k++) begin
            d1_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         d1_valid_ff[0] <= s1_valid_ff[SQRT_STEPS];
         for (int k = 1; k <= DIV1_STEPS; k++) begin
            d1_valid_ff[k] <= d1_valid_ff[k-1];
         end
      end
      if (adv) begin
         d1_side_ff[0] <= d1_side_in;
         for (int k = 0; k <= DIV1_STEPS; k++) begin
            d1_rem_ff[k] <= d1_rem_in[k];
            d1_q_ff[k]   <= d1_q_in[k];
         end
         for (int k = 1; k <= DIV1_STEPS; k++) begin
            d1_side_ff[k] <= d1_side_ff[k-1];
         end
      end
   end

   // Transmitted cosine: square root of one minus sine squared.
   logic [60:0] s2_v_ff [SQRT_STEPS+1];
   logic [60:0] s2_r_ff [SQRT_STEPS+1];
   logic [60:0] s2_v_in [SQRT_STEPS+1];
   logic [60:0] s2_r_in [SQRT_STEPS+1];
   side_type    s2_side_ff [SQRT_STEPS+1];
   logic        s2_valid_ff [SQRT_STEPS+1];
   logic [59:0] ssq_in;

   assign ssq_in = d1_q_ff[DIV1_STEPS] * d1_q_ff[DIV1_STEPS];
   assign s2_v_in[0] = ONE_Q60 - 61'(ssq_in);
   assign s2_r_in[0] = '0;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt2
      logic [121:0] step;
      assign step = sqrt_step(s2_v_ff[j], s2_r_ff[j], 61'(1) << (2 * (SQRT_STEPS - 1 - j)));
      assign s2_v_in[j+1] = step[121:61];
      assign s2_r_in[j+1] = step[60:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            s2_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s2_valid_ff[0] <= d1_valid_ff[DIV1_STEPS];
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            s2_valid_ff[k] <= s2_valid_ff[k-1];
         end
      end
      if (adv) begin
         s2_side_ff[0] <= d1_side_ff[DIV1_STEPS];
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            s2_v_ff[k] <= s2_v_in[k];
            s2_r_ff[k] <= s2_r_in[k];
         end
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            s2_side_ff[k] <= s2_side_ff[k-1];
         end
      end
   end

   // Stage F: index-weighted cosine products.
   logic f_valid_ff;
   side_type f_side_ff;
   logic [32:0] f_prod_ff [4];
   logic [16:0] cq, tq;
   side_type s2_out;

   assign s2_out = s2_side_ff[SQRT_STEPS];
   assign cq = s2_out.cos_i[30:14];
   assign tq = s2_r_ff[SQRT_STEPS][30:14];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= s2_valid_ff[SQRT_STEPS];
      end
      if (adv) begin
         f_side_ff    <= s2_out;
         f_prod_ff[0] <= s2_out.eta_t * cq;
         f_prod_ff[1] <= s2_out.eta_i * tq;
         f_prod_ff[2] <= s2_out.eta_i * cq;
         f_prod_ff[3] <= s2_out.eta_t * tq;
      end
   end

   // Amplitude ratios, s and p lanes side by side.
   div_lane_type d2_lane_ff [DIV2_STEPS+1][2];
   div_lane_type d2_lane_in [DIV2_STEPS+1][2];
   side_type     d2_side_ff [DIV2_STEPS+1];
   logic         d2_valid_ff [DIV2_STEPS+1];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [32:0] a, b;
      assign a = f_prod_ff[2*l];
      assign b = f_prod_ff[2*l+1];
      always_comb begin
         d2_lane_in[0][l].rem      = (a >= b) ? 34'(a - b) : 34'(b - a);
         d2_lane_in[0][l].den      = 34'(a) + 34'(b);
         d2_lane_in[0][l].quo      = '0;
         d2_lane_in[0][l].den_zero = (a == 33'd0) && (b == 33'd0);
      end
      for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_step
         logic [34:0] rem2;
         logic        take;
         if (j == 0) begin : g_first
            assign rem2 = {1'b0, d2_lane_ff[j][l].rem};
         end else begin : g_next
            assign rem2 = {d2_lane_ff[j][l].rem, 1'b0};
         end
         assign take = rem2 >= {1'b0, d2_lane_ff[j][l].den};
         always_comb begin
            d2_lane_in[j+1][l] = d2_lane_ff[j][l];
            d2_lane_in[j+1][l].rem = take ? 34'(rem2 - {1'b0, d2_lane_ff[j][l].den})
                                          : rem2[33:0];
            d2_lane_in[j+1][l].quo = {d2_lane_ff[j][l].quo[29:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV2_STEPS; k++) begin
            d2_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         d2_valid_ff[0] <= f_valid_ff;
         for (int k = 1; k <= DIV2_STEPS; k++) begin
            d2_valid_ff[k] <= d2_valid_ff[k-1];
         end
      end
      if (adv) begin
         d2_side_ff[0] <= f_side_ff;
         for (int k = 0; k <= DIV2_STEPS; k++) begin
            d2_lane_ff[k][0] <= d2_lane_in[k][0];
            d2_lane_ff[k][1] <= d2_lane_in[k][1];
         end
         for (int k = 1; k <= DIV2_STEPS; k++) begin
            d2_side_ff[k] <= d2_side_ff[k-1];
         end
      end
   end

   // Stage H: squared ratios.
   logic h_valid_ff;
   logic h_tir_ff;
   logic [61:0] h_sq_ff [2];
   logic [30:0] ratio [2];

   for (genvar l = 0; l < 2; l++) begin : g_ratio
      assign ratio[l] = d2_lane_ff[DIV2_STEPS][l].den_zero ? ONE_Q30
                                                           : d2_lane_ff[DIV2_STEPS][l].quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= d2_valid_ff[DIV2_STEPS];
      end
      if (adv) begin
         h_tir_ff   <= d2_side_ff[DIV2_STEPS].tir;
         h_sq_ff[0] <= ratio[0] * ratio[0];
         h_sq_ff[1] <= ratio[1] * ratio[1];
      end
   end

   // Output register: mean of the squares, saturated.
   logic [62:0] refl_sum;
   logic [16:0] refl_q15;

   assign refl_sum = 63'(h_sq_ff[0]) + 63'(h_sq_ff[1]) + HALF_Q46;
   assign refl_q15 = refl_sum[62:46];
   assign rsp_reflectance_in = (h_tir_ff || refl_q15 > 17'(REFL_ONE)) ? REFL_ONE
                                                                       : refl_q15[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= h_valid_ff;
      end
      if (adv) begin
         rsp_reflectance_ff    <= rsp_reflectance_in;
         rsp_total_internal_ff <= h_tir_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reflectance    = rsp_reflectance_ff;
   assign rsp_total_internal = rsp_total_internal_ff;

`ifndef SYNTHESIS
   a_tir_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_total_internal_ff |-> rsp_reflectance_ff == REFL_ONE)
      else $error("total internal reflection item without full reflectance");

   a_refl_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_reflectance_ff <= REFL_ONE)
      else $error("reflectance above one");

   a_cos_clamp : assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> b_side_ff.cos_i <= ONE_Q30)
      else $error("cosine beyond clamp");

   a_zero_index_tir : assert property (@(posedge clock) disable iff (reset)
      d1_valid_ff[0] && d1_side_ff[0].eta_t == 16'd0 |-> d1_side_ff[0].tir)
      else $error("zero transmit index not flagged as total internal reflection");
`endif

endmodule

@@ verif/fresnel_reflectance_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fresnel reflectance checker
// Watches both channels of the reflectance block, computes the expected
// reflectance of every accepted item and compares each result in order.
// ----------------------------------------------------------------------------
module fresnel_reflectance_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_incident_x,
   input  logic signed [15:0] req_incident_y,
   input  logic signed [15:0] req_incident_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic        [15:0] req_index_incident,
   input  logic        [15:0] req_index_transmit,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic        [15:0] rsp_reflectance,
   input  logic               rsp_total_internal,
   output int                 failures,
   output int                 pending,
   output int                 tir_seen
);

   typedef struct {
      logic [15:0] reflectance;
      logic        total_internal;
   } shade_type;

   shade_type shades_due[$];

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] ratio_q30(logic [63:0] a, logic [63:0] b);
      logic [63:0] num;
      num = (a >= b) ? a - b : b - a;
      if (a + b == 0) return 64'd1 << 30;
      return (num << 30) / (a + b);
   endfunction

   function automatic shade_type shade(logic signed [15:0] ix, iy, iz, nx, ny, nz,
                                       logic [15:0] n_in, n_out);
      shade_type s;
      logic signed [63:0] dot;
      logic [63:0] mag, c, ei, et, sini, sint, cost, rs, rp, r;
      dot = 64'(ix) * 64'(nx) + 64'(iy) * 64'(ny) + 64'(iz) * 64'(nz);
      mag = (dot < 0) ? -dot : dot;
      c = mag << 2;
      if (c > (64'd1 << 30)) c = 64'd1 << 30;
      ei = dot > 0 ? n_out : n_in;
      et = dot > 0 ? n_in : n_out;
      sini = floor_root((64'd1 << 60) - c * c);
      if (et == 0 || ei * sini >= et * (64'd1 << 30)) begin
         s.reflectance = 16'h8000;
         s.total_internal = 1'b1;
         return s;
      end
      sint = (ei * sini) / et;
      cost = floor_root((64'd1 << 60) - sint * sint);
      rs = ratio_q30(et * (c >> 14), ei * (cost >> 14));
      rp = ratio_q30(ei * (c >> 14), et * (cost >> 14));
      r = (rs * rs + rp * rp + (64'd1 << 45)) >> 46;
      if (r > 32768) r = 32768;
      s.reflectance = r[15:0];
      s.total_internal = 1'b0;
      return s;
   endfunction

   initial begin
      failures = 0;
      tir_seen = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      shade_type want;
      if (!reset && req_valid && !req_stall)
         shades_due.push_back(shade(req_incident_x, req_incident_y, req_incident_z,
                                    req_normal_x, req_normal_y, req_normal_z,
                                    req_index_incident, req_index_transmit));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shades_due.size() == 0) begin
            $error("result with no item outstanding");
            failures++;
         end else begin
            want = shades_due.pop_front();
            if (rsp_total_internal) tir_seen++;
            if (rsp_reflectance !== want.reflectance) begin
               $error("reflectance expected %0d actual %0d", want.reflectance,
                      rsp_reflectance);
               failures++;
            end
            if (rsp_total_internal !== want.total_internal) begin
               $error("total_internal expected %0d actual %0d", want.total_internal,
                      rsp_total_internal);
               failures++;
            end
         end
      end
      pending = shades_due.size();
   end

endmodule

@@ verif/fresnel_reflectance_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fresnel reflectance test
// Drives directed and random surface hits through the reflectance block with
// bursty input, patterned result stalls and one long hold-off.
// ----------------------------------------------------------------------------
module fresnel_reflectance_test;

   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_HITS = 1700;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [15:0] req_incident_x = 0, req_incident_y = 0, req_incident_z = 0;
   logic signed [15:0] req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   logic        [15:0] req_index_incident = 0, req_index_transmit = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic        [15:0] rsp_reflectance;
   logic               rsp_total_internal;
   int                 failures, pending, tir_seen;
   int                 hits_sent = 0;
   int                 idle_cycles = 0;
   int                 hold_off = 0;
   bit                 held_off = 0;

   fresnel_reflectance dut (.*);
   fresnel_reflectance_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic logic signed [15:0] unit_part();
      case ($urandom_range(0, 5))
         0: return 16'sh4000;
         1: return -16'sh4000;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [15:0] pick_index();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(4096, 10240));
      endcase
   endfunction

   task automatic send_hit(logic signed [15:0] ix, iy, iz, nx, ny, nz,
                           logic [15:0] n_in, n_out);
      req_valid <= 1;
      req_incident_x <= ix;
      req_incident_y <= iy;
      req_incident_z <= iz;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_index_incident <= n_in;
      req_index_transmit <= n_out;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hits_sent++;
   endtask

   task automatic maybe_gap();
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else if (!held_off && hits_sent == 600) begin
         hold_off <= 400;
         held_off <= 1;
         rsp_stall <= 1;
      end else begin
         case ((hits_sent / 200) % 3)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int burst;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_hit(-16'sh4000, 0, 0, 16'sh4000, 0, 0, 4096, 6144);
      send_hit(16'sh4000, 0, 0, 16'sh4000, 0, 0, 4096, 6144);
      send_hit(0, -16'sh4000, 0, 0, 16'sh4000, 0, 4096, 4096);
      send_hit(16'sh4000, 0, 0, 0, 16'sh4000, 0, 4096, 6144);
      send_hit(16'sh2d41, 16'sh2d41, 0, 0, 16'sh4000, 0, 6144, 4096);
      send_hit(-16'sh2d41, -16'sh2d41, 0, 0, 16'sh4000, 0, 6144, 4096);
      send_hit(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
               -16'sh8000, 16'hffff, 16'h0001);
      send_hit(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
               -16'sh8000, 16'h0001, 16'hffff);
      send_hit(0, 0, 0, 0, 0, 0, 4096, 4096);
      send_hit(0, 0, 0, 0, 0, 0, 0, 0);
      send_hit(-16'sh4000, 0, 0, 16'sh4000, 0, 0, 4096, 0);
      send_hit(16'sh4000, 0, 0, 16'sh4000, 0, 0, 0, 4096);
      send_hit(-16'sh4000, 0, 0, 16'sh4000, 0, 0, 0, 4096);
      send_hit(16'sh3000, 0, 0, 16'sh4000, 0, 0, 16'hffff, 16'hffff);
      send_hit(-16'sh0100, 0, 0, 16'sh4000, 0, 0, 16'hffff, 4096);
      while (hits_sent < RANDOM_HITS + 15) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            if ($urandom_range(0, 4) == 0)
               send_hit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
               send_hit(unit_part(), unit_part(), unit_part(), unit_part(),
                        unit_part(), unit_part(), pick_index(), pick_index());
         end
         maybe_gap();
      end
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d surface hits, %0d of them totally reflected,", hits_sent,
               tir_seen);
      $display("with bursty input, random result stalls and one long hold-off.");
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
